// ===== sv/rpmm_pkg.sv =====
package rpmm_pkg;

    localparam int NODE_POOL_DEF  = 64;
    localparam int LEVEL_BITS_DEF = 9;
    localparam int LEVELS_DEF     = 4;

    localparam int PN_W   = 36;
    localparam int META_W = 32;

    localparam logic ACT_SET = 1'b0;
    localparam logic ACT_GET = 1'b1;

    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_EXHAUSTED = 1'b1;

    typedef struct packed {
        logic [META_W-1:0] meta;
        logic              hit;
        logic              status;
    } rpmm_result_t;

endpackage

// ===== sv/radix_page_metadata_map.sv =====
// four-level radix map from page number to a 32-bit metadata handle
// input beat: action (set or get), page_number, meta_value; one result beat per input
// result beat: meta_out, hit, status (pool exhausted on set)
// both channels: beat moves when valid is high and stall is low
// all node entries live in one ram with a single registered read port
// each level takes two states: S_RD (address), then S_WT (read data and optional node link)
// a full walk visits every level before its result is offered; the next beat
// is accepted once the walk has handed its result on to the output register;
// a get that misses at an interior level skips the remaining levels and finishes sooner
// one item in flight at a time; in_stall is high while a walk runs
// a finished result sits in the output register; the next item is accepted
// while it waits, and its own result is held until the output register frees
// when out_stall holds, out_valid and the result fields stay put
// after reset a clear sweep zeroes the ram, one entry a cycle, over all
// NODE_POOL * 2^LEVEL_BITS entries, 32768 at the defaults, with in_stall high
// the node count returns to one (root only) at reset
module radix_page_metadata_map #(
    parameter int NODE_POOL  = rpmm_pkg::NODE_POOL_DEF,
    parameter int LEVEL_BITS = rpmm_pkg::LEVEL_BITS_DEF,
    parameter int LEVELS     = rpmm_pkg::LEVELS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        action,
    input  logic [rpmm_pkg::PN_W-1:0]   page_number,
    input  logic [rpmm_pkg::META_W-1:0] meta_value,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [rpmm_pkg::META_W-1:0] meta_out,
    output logic                        hit,
    output logic                        status
);

    localparam int DEPTH = NODE_POOL * (1 << LEVEL_BITS);
    localparam int AW    = $clog2(NODE_POOL) + LEVEL_BITS;

    logic                        res_valid;
    logic                        res_ready;
    rpmm_pkg::rpmm_result_t      res;
    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [rpmm_pkg::META_W-1:0] ram_wdata;
    logic [AW-1:0]               ram_raddr;
    logic [rpmm_pkg::META_W-1:0] ram_rdata;

    rpmm_ram #(
        .WIDTH (rpmm_pkg::META_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    rpmm_walk #(
        .NODE_POOL  (NODE_POOL),
        .LEVEL_BITS (LEVEL_BITS),
        .LEVELS     (LEVELS)
    ) u_walk (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .page_number (page_number),
        .meta_value  (meta_value),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata)
    );

    rpmm_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .meta_out  (meta_out),
        .hit       (hit),
        .status    (status)
    );

    // accepted beat starts a walk
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("walk not started after accepted beat");

    // no pending result while idle
    a_idle_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> !res_valid)
        else $error("result pending while walker idle");

    // a held result does not change
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(res)))
        else $error("pending result dropped or changed");

    // exhaustion reports no handle
    a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.status) |-> (!res.hit && res.meta == '0))
        else $error("exhausted set carries a handle");

endmodule

// ===== sv/rpmm_ram.sv =====
module rpmm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/rpmm_walk.sv =====
module rpmm_walk #(
    parameter int NODE_POOL  = rpmm_pkg::NODE_POOL_DEF,
    parameter int LEVEL_BITS = rpmm_pkg::LEVEL_BITS_DEF,
    parameter int LEVELS     = rpmm_pkg::LEVELS_DEF,
    localparam int NW        = $clog2(NODE_POOL),
    localparam int AW        = NW + LEVEL_BITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        action,
    input  logic [rpmm_pkg::PN_W-1:0]   page_number,
    input  logic [rpmm_pkg::META_W-1:0] meta_value,
    output logic                        res_valid,
    input  logic                        res_ready,
    output rpmm_pkg::rpmm_result_t      res,
    output logic                        ram_we,
    output logic [AW-1:0]               ram_waddr,
    output logic [rpmm_pkg::META_W-1:0] ram_wdata,
    output logic [AW-1:0]               ram_raddr,
    input  logic [rpmm_pkg::META_W-1:0] ram_rdata
);

    localparam int DEPTH = NODE_POOL * (1 << LEVEL_BITS);
    localparam int NUW   = $clog2(NODE_POOL + 1);
    localparam int LVW   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int EXT_W = rpmm_pkg::PN_W + LEVELS * LEVEL_BITS;

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_WT   = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]                  state_reg, state_next;
    logic [AW-1:0]               clr_cnt_reg, clr_cnt_next;
    logic [NUW-1:0]              nodes_used_reg, nodes_used_next;
    logic [LVW-1:0]              lvl_reg, lvl_next;
    logic [NW-1:0]               node_reg, node_next;
    logic                        action_reg, action_next;
    logic [rpmm_pkg::PN_W-1:0]   pn_reg, pn_next;
    logic [rpmm_pkg::META_W-1:0] meta_reg, meta_next;
    rpmm_pkg::rpmm_result_t      res_reg, res_next;

    logic [EXT_W-1:0]      pn_ext;
    logic [LEVEL_BITS-1:0] idx_arr [LEVELS];
    logic [LEVEL_BITS-1:0] idx_cur;
    logic                  is_leaf;
    logic                  present;
    logic                  pool_full;

    assign pn_ext = EXT_W'(pn_reg);

    always_comb
    begin
        for (int l = 0; l < LEVELS; l++)
        begin
            idx_arr[l] = LEVEL_BITS'(pn_ext >> ((LEVELS - 1 - l) * LEVEL_BITS));
        end
    end

    assign idx_cur   = idx_arr[lvl_reg];
    assign is_leaf   = lvl_reg == LVW'(LEVELS - 1);
    assign present   = (ram_rdata != '0) && (ram_rdata < rpmm_pkg::META_W'(nodes_used_reg));
    assign pool_full = nodes_used_reg >= NUW'(NODE_POOL);

    assign in_stall  = state_reg != S_IDLE;
    assign res_valid = state_reg == S_FIN;
    assign res       = res_reg;
    assign ram_raddr = {node_reg, idx_cur};

    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        nodes_used_next = nodes_used_reg;
        lvl_next        = lvl_reg;
        node_next       = node_reg;
        action_next     = action_reg;
        pn_next         = pn_reg;
        meta_next       = meta_reg;
        res_next        = res_reg;
        ram_we          = 1'b0;
        ram_waddr       = {node_reg, idx_cur};
        ram_wdata       = meta_reg;

        unique case (state_reg)
            S_CLR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    action_next = action;
                    pn_next     = page_number;
                    meta_next   = meta_value;
                    lvl_next    = '0;
                    node_next   = '0;
                    state_next  = S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_WT;
            end
            S_WT:
            begin
                res_next = '{meta: '0, hit: 1'b0, status: rpmm_pkg::STATUS_OK};
                if (is_leaf)
                begin
                    if (action_reg == rpmm_pkg::ACT_SET)
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = meta_reg;
                    end
                    else
                    begin
                        res_next.meta = ram_rdata;
                        res_next.hit  = ram_rdata != '0;
                    end
                    state_next = S_FIN;
                end
                else if (present)
                begin
                    node_next  = ram_rdata[NW-1:0];
                    lvl_next   = lvl_reg + 1'b1;
                    state_next = S_RD;
                end
                else if (action_reg == rpmm_pkg::ACT_GET)
                begin
                    state_next = S_FIN;
                end
                else if (pool_full)
                begin
                    res_next.status = rpmm_pkg::STATUS_EXHAUSTED;
                    state_next      = S_FIN;
                end
                else
                begin
                    // link a fresh node, still zero since the clear sweep
                    ram_we          = 1'b1;
                    ram_wdata       = rpmm_pkg::META_W'(nodes_used_reg);
                    node_next       = nodes_used_reg[NW-1:0];
                    nodes_used_next = nodes_used_reg + 1'b1;
                    lvl_next        = lvl_reg + 1'b1;
                    state_next      = S_RD;
                end
            end
            S_FIN:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLR;
            clr_cnt_reg    <= '0;
            nodes_used_reg <= NUW'(1);
            lvl_reg        <= '0;
            node_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            nodes_used_reg <= nodes_used_next;
            lvl_reg        <= lvl_next;
            node_reg       <= node_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg <= action_next;
        pn_reg     <= pn_next;
        meta_reg   <= meta_next;
        res_reg    <= res_next;
    end

endmodule

// ===== sv/rpmm_out.sv =====
module rpmm_out (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        res_valid,
    output logic                        res_ready,
    input  rpmm_pkg::rpmm_result_t      res,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [rpmm_pkg::META_W-1:0] meta_out,
    output logic                        hit,
    output logic                        status
);

    logic                   valid_reg, valid_next;
    rpmm_pkg::rpmm_result_t data_reg, data_next;

    assign res_ready = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (res_ready)
        begin
            valid_next = res_valid;
            if (res_valid)
            begin
                data_next = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign meta_out  = data_reg.meta;
    assign hit       = data_reg.hit;
    assign status    = data_reg.status;

endmodule

// ===== dv/radix_map_checker.sv =====
module radix_map_checker #(
    parameter int NODE_POOL  = rpmm_pkg::NODE_POOL_DEF,
    parameter int LEVEL_BITS = rpmm_pkg::LEVEL_BITS_DEF,
    parameter int LEVELS     = rpmm_pkg::LEVELS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  logic                        action,
    input  logic [rpmm_pkg::PN_W-1:0]   page_number,
    input  logic [rpmm_pkg::META_W-1:0] meta_value,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic [rpmm_pkg::META_W-1:0] meta_out,
    input  logic                        hit,
    input  logic                        status,
    output int                          fail_count,
    output int                          outstanding
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FANOUT = 1 << LEVEL_BITS;
    localparam int DEPTH  = NODE_POOL * FANOUT;

    logic [rpmm_pkg::META_W-1:0] node_mem [DEPTH];
    int unsigned                 nodes_taken;
    rpmm_pkg::rpmm_result_t      due_results [$];

    function automatic int unsigned level_index(logic [rpmm_pkg::PN_W-1:0] pn, int lvl);
        int sh;
        sh = (LEVELS - 1 - lvl) * LEVEL_BITS;
        if (sh >= 64)
        begin
            return 0;
        end
        return int'((64'(pn) >> sh) & 64'(FANOUT - 1));
    endfunction

    // walks the map the way the block does and updates the shadow copy
    task automatic walk_map(input logic act, input logic [rpmm_pkg::PN_W-1:0] pn,
                            input logic [rpmm_pkg::META_W-1:0] meta,
                            output rpmm_pkg::rpmm_result_t res);
        int unsigned node;
        int unsigned slot;
        int unsigned child;
        bit          done;
        res        = '0;
        res.status = rpmm_pkg::STATUS_OK;
        node       = 0;
        done       = 1'b0;
        for (int lvl = 0; lvl < LEVELS - 1 && !done; lvl++)
        begin
            slot  = (node * FANOUT + level_index(pn, lvl)) % DEPTH;
            child = node_mem[slot];
            if (child == 0 || child >= nodes_taken)
            begin
                if (act == rpmm_pkg::ACT_GET)
                begin
                    done = 1'b1;
                end
                else if (nodes_taken >= NODE_POOL)
                begin
                    res.status = rpmm_pkg::STATUS_EXHAUSTED;
                    done       = 1'b1;
                end
                else
                begin
                    child          = nodes_taken;
                    nodes_taken    = nodes_taken + 1;
                    node_mem[slot] = rpmm_pkg::META_W'(child);
                end
            end
            node = child;
        end
        if (!done)
        begin
            slot = (node * FANOUT + level_index(pn, LEVELS - 1)) % DEPTH;
            if (act == rpmm_pkg::ACT_SET)
            begin
                node_mem[slot] = meta;
            end
            else
            begin
                res.meta = node_mem[slot];
                res.hit  = node_mem[slot] != '0;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rpmm_pkg::rpmm_result_t res;
        rpmm_pkg::rpmm_result_t want;
        if (!rst_n)
        begin
            foreach (node_mem[i])
            begin
                node_mem[i] = '0;
            end
            nodes_taken = 1;
            due_results.delete();
            fail_count  = 0;
            outstanding = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (due_results.size() == 0)
                begin
                    $error("result beat with nothing pending: meta_out %h hit %b status %b",
                           meta_out, hit, status);
                    fail_count++;
                end
                else
                begin
                    want = due_results.pop_front();
                    if (meta_out !== want.meta)
                    begin
                        $error("meta_out: expected %h, actual %h", want.meta, meta_out);
                        fail_count++;
                    end
                    if (hit !== want.hit)
                    begin
                        $error("hit: expected %b, actual %b", want.hit, hit);
                        fail_count++;
                    end
                    if (status !== want.status)
                    begin
                        $error("status: expected %b, actual %b", want.status, status);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                walk_map(action, page_number, meta_value, res);
                due_results.push_back(res);
            end
            outstanding = due_results.size();
        end
    end

endmodule

// ===== dv/tb_radix_page_metadata_map.sv =====
module tb_radix_page_metadata_map;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 4;
    localparam int IW           = rpmm_pkg::LEVEL_BITS_DEF;
    localparam int RANDOM_ITEMS = 1080;
    localparam int PAUSE_AT     = 350;
    localparam int HOLD_AT      = 650;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;
    // clear sweep after reset zeroes 32768 ram entries with no beats moving
    localparam int IDLE_LIMIT   = 150000;

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_stall;
    logic                        action;
    logic [rpmm_pkg::PN_W-1:0]   page_number;
    logic [rpmm_pkg::META_W-1:0] meta_value;
    logic                        out_valid;
    logic                        out_stall;
    logic [rpmm_pkg::META_W-1:0] meta_out;
    logic                        hit;
    logic                        status;

    int fail_count;
    int outstanding;
    int items_sent;

    logic [IW-1:0]             hot_idx [4][4];
    logic [rpmm_pkg::PN_W-1:0] mapped_pages [$];

    always #(CLK_PERIOD / 2) clk = ~clk;

    radix_page_metadata_map dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .page_number (page_number),
        .meta_value  (meta_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .meta_out    (meta_out),
        .hit         (hit),
        .status      (status)
    );

    radix_map_checker map_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .page_number (page_number),
        .meta_value  (meta_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .meta_out    (meta_out),
        .hit         (hit),
        .status      (status),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    function automatic logic [rpmm_pkg::PN_W-1:0] page_of(logic [IW-1:0] i0,
                                                          logic [IW-1:0] i1,
                                                          logic [IW-1:0] i2,
                                                          logic [IW-1:0] i3);
        return {i0, i1, i2, i3};
    endfunction

    // mostly shared prefixes so walks go deep and the pool drains gradually
    function automatic logic [rpmm_pkg::PN_W-1:0] fresh_page();
        logic [IW-1:0] idx [4];
        for (int l = 0; l < 4; l++)
        begin
            if ($urandom_range(0, 99) < (l == 3 ? 50 : 75))
            begin
                idx[l] = hot_idx[l][$urandom_range(0, 3)];
            end
            else
            begin
                idx[l] = IW'($urandom);
            end
        end
        return page_of(idx[0], idx[1], idx[2], idx[3]);
    endfunction

    function automatic logic [rpmm_pkg::META_W-1:0] pick_meta();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
        begin
            return '0;
        end
        if (r < 15)
        begin
            return '1;
        end
        return rpmm_pkg::META_W'($urandom);
    endfunction

    task automatic issue(input logic act, input logic [rpmm_pkg::PN_W-1:0] pn,
                         input logic [rpmm_pkg::META_W-1:0] meta);
        int r;
        int gap;
        in_valid    <= 1'b1;
        action      <= act;
        page_number <= pn;
        meta_value  <= meta;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        items_sent++;
        if (act == rpmm_pkg::ACT_SET)
        begin
            mapped_pages.push_back(pn);
        end
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            gap = 0;
        end
        else if (r < 92)
        begin
            gap = $urandom_range(1, 3);
        end
        else
        begin
            gap = $urandom_range(10, 40);
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic random_item();
        logic [rpmm_pkg::PN_W-1:0] pn;
        bit                        known;
        known = mapped_pages.size() > 0 && $urandom_range(0, 99) < 70;
        if (known)
        begin
            pn = mapped_pages[$urandom_range(0, mapped_pages.size() - 1)];
        end
        else
        begin
            pn = fresh_page();
        end
        if ($urandom_range(0, 99) < 50)
        begin
            issue(rpmm_pkg::ACT_GET, pn, rpmm_pkg::META_W'($urandom));
        end
        else
        begin
            issue(rpmm_pkg::ACT_SET, pn, pick_meta());
        end
    endtask

    // result side: short stalls, long stalls, free-running stretches, one long hold
    initial
    begin
        int  r;
        bit  held;
        held = 1'b0;
        out_stall <= 1'b0;
        forever
        begin
            r = $urandom_range(0, 99);
            if (!held && items_sent >= HOLD_AT)
            begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (r < 40)
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 30)) @(posedge clk);
            end
            else if (r < 90)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(10, 60)) @(posedge clk);
            end
        end
    end

    initial
    begin
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                idle = 0;
            end
            else
            begin
                idle++;
            end
        end
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        items_sent = 0;
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        action      <= rpmm_pkg::ACT_SET;
        page_number <= '0;
        meta_value  <= '0;
        for (int l = 0; l < 4; l++)
        begin
            hot_idx[l][0] = '0;
            hot_idx[l][1] = '1;
            hot_idx[l][2] = IW'($urandom);
            hot_idx[l][3] = IW'($urandom);
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty map, then a first path
        issue(rpmm_pkg::ACT_GET, page_of('0, '0, '0, '0), '1);
        issue(rpmm_pkg::ACT_SET, page_of('0, '0, '0, '0), '1);
        issue(rpmm_pkg::ACT_GET, page_of('0, '0, '0, '0), '0);
        // misses at the leaf and at each interior level
        issue(rpmm_pkg::ACT_GET, page_of('0, '0, '0, IW'(1)), '0);
        issue(rpmm_pkg::ACT_GET, page_of('0, '0, IW'(1), '0), '0);
        issue(rpmm_pkg::ACT_GET, page_of('0, IW'(1), '0, '0), '0);
        issue(rpmm_pkg::ACT_GET, page_of('1, '1, '1, '1), '0);
        // set of zero still builds the path
        issue(rpmm_pkg::ACT_SET, page_of('1, '1, '1, '1), '0);
        issue(rpmm_pkg::ACT_GET, page_of('1, '1, '1, '1), '0);
        issue(rpmm_pkg::ACT_GET, page_of('1, '1, '1, '0), '0);
        issue(rpmm_pkg::ACT_SET, page_of('1, '1, '1, '1), 32'h0000_0001);
        issue(rpmm_pkg::ACT_GET, page_of('1, '1, '1, '1), '1);
        // clear a live entry
        issue(rpmm_pkg::ACT_SET, page_of('0, '0, '0, '0), '0);
        issue(rpmm_pkg::ACT_GET, page_of('0, '0, '0, '0), '0);
        issue(rpmm_pkg::ACT_SET, page_of('0, '0, '0, IW'(1)), 32'hA5A5_5A5A);
        issue(rpmm_pkg::ACT_GET, page_of('0, '0, '0, IW'(1)), '0);
        issue(rpmm_pkg::ACT_SET, 36'h5_5555_5555, 32'h8000_0000);
        issue(rpmm_pkg::ACT_GET, 36'hA_AAAA_AAAA, '0);
        issue(rpmm_pkg::ACT_GET, 36'h5_5555_5555, 32'h5555_5555);
        issue(rpmm_pkg::ACT_SET, 36'hA_AAAA_AAAA, 32'h7FFF_FFFF);
        issue(rpmm_pkg::ACT_GET, 36'hA_AAAA_AAAA, '0);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == PAUSE_AT)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                wait (outstanding == 0);
            end
            random_item();
        end

        in_valid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
